// ===== src/lht_pkg.sv =====
package lht_pkg;

  // default geometry
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 31;

  // field and register widths
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int CFG_W    = 11;
  localparam int TAG_W    = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // slot tags
  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_GONE  = 2'd2;

  // register index (paddr[2])
  localparam logic REG_HASH_MODULUS = 1'b0;
  localparam logic REG_PROBE_LIMIT  = 1'b1;

  // status reported when the probe sequence runs out
  function automatic logic [STATUS_W-1:0] miss_status(input logic [OP_W-1:0] op);
    miss_status = (op == OP_INSERT) ? ST_FULL : ST_ABSENT;
  endfunction

endpackage

// ===== src/lht_rem.sv =====
// Restoring remainder unit, one dividend bit per cycle.
module lht_rem #(
  parameter int KEY_WIDTH = 31,
  parameter int ADDR_W    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] dividend,
  input  logic [ADDR_W:0]      divisor,
  output logic                 done,
  output logic [ADDR_W-1:0]    rem
);

  localparam int CNT_W = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [KEY_WIDTH-1:0] dvd;
  logic [ADDR_W:0]      part;
  logic [ADDR_W:0]      part_next;
  logic [ADDR_W+1:0]    trial;
  logic [ADDR_W+1:0]    dsr_ext;

  assign trial   = {part, dvd[KEY_WIDTH-1]};
  assign dsr_ext = {1'b0, divisor};

  always_comb begin
    if (trial >= dsr_ext) begin
      part_next = (ADDR_W+1)'(trial - dsr_ext);
    end else begin
      part_next = trial[ADDR_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // last dividend bit goes in this cycle
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(KEY_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      part <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      part <= part_next;
    end
  end

  // partial remainder stays below divisor <= depth
  assign rem = part[ADDR_W-1:0];

endmodule

// ===== src/linear_probe_hash_table_core.sv =====
// Open-addressing hash table, linear probing, iterative.
// From an accepted transaction to m_tvalid: a bit-serial remainder unit finds the
//   home slot (S_DIV), each probe is a slot read (S_READ) and a check (S_CHECK), then
//   S_RESP loads the result once the output register is free; an unused opcode goes
//   straight to S_RESP. One transaction at a time; s_tready is high only while idle.
// Reset: synchronous; registers return to 1024, then a clearing pass empties every slot.
module linear_probe_hash_table_core
  import lht_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,

  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] operation, [KEY_WIDTH+1:2] key, upper bits zero
  input  logic [((OP_W+KEY_WIDTH+7)/8)*8-1:0] s_tdata,

  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [11:2] slot_index, [15:12] zero
  output logic [15:0] m_tdata,

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int ENT_W = TAG_W + KEY_WIDTH;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_W-1:0] hash_modulus;
  logic [CFG_W-1:0] probe_limit;
  logic             cfg_wr;

  // transaction context
  logic [OP_W-1:0]      op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [AW-1:0]        pos;
  logic [CFG_W-1:0]     cnt;
  logic [STATUS_W-1:0]  res_status;
  logic [AW-1:0]        res_slot;
  logic [AW-1:0]        clr_cnt;

  // derived
  logic [CW-1:0]   mod_ext;
  logic [AW:0]     eff_mod;
  logic [AW:0]     pos_inc;
  logic [AW-1:0]   pos_wrap;
  logic            s_acc;
  logic [OP_W-1:0] in_op;
  logic [KEY_WIDTH-1:0] in_key;

  // remainder unit
  logic          rem_start;
  logic          rem_done;
  logic [AW-1:0] rem;

  // slot store
  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [TAG_W-1:0] rd_tag;
  logic             key_hit;

  // output packing
  logic [AW+SLOT_W-1:0] slot_wide;

  // ---------------------------------------------------------------
  // APB: always ready, writes land on the access cycle
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PROBE_LIMIT) ? 32'(probe_limit) : 32'(hash_modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_modulus <= CFG_RESET;
      probe_limit  <= CFG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HASH_MODULUS) begin
        hash_modulus <= pwdata[CFG_W-1:0];
      end else begin
        probe_limit <= pwdata[CFG_W-1:0];
      end
    end
  end

  // effective modulus: zero acts as one, clamp to the table depth
  assign mod_ext = CW'(hash_modulus);
  always_comb begin
    if (hash_modulus == '0) begin
      eff_mod = (AW+1)'(1);
    end else if (mod_ext > CW'(TABLE_DEPTH)) begin
      eff_mod = (AW+1)'(TABLE_DEPTH);
    end else begin
      eff_mod = mod_ext[AW:0];
    end
  end

  // next probe position, wrapping at the modulus
  assign pos_inc  = {1'b0, pos} + (AW+1)'(1);
  assign pos_wrap = (pos_inc == eff_mod) ? '0 : pos_inc[AW-1:0];

  // ---------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign in_op     = s_tdata[OP_W-1:0];
  assign in_key    = s_tdata[OP_W+KEY_WIDTH-1:OP_W];
  assign rem_start = s_acc && (in_op != OP_UNUSED);

  lht_rem #(
    .KEY_WIDTH (KEY_WIDTH),
    .ADDR_W    (AW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (in_key),
    .divisor  (eff_mod),
    .done     (rem_done),
    .rem      (rem)
  );

  // ---------------------------------------------------------------
  // probe check
  // ---------------------------------------------------------------
  assign rd_tag  = rd_q[ENT_W-1:KEY_WIDTH];
  assign key_hit = (rd_tag == TAG_USED) && (rd_q[KEY_WIDTH-1:0] == key_q);

  // single write port: clearing pass, insert into a free slot, or delete hit (S_CHECK)
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {TAG_USED, key_q};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = {TAG_EMPTY, {KEY_WIDTH{1'b0}}};
      end
      S_CHECK: begin
        if (op_q == OP_INSERT) begin
          mem_we = (rd_tag != TAG_USED);
        end else if (op_q == OP_DELETE) begin
          mem_we    = key_hit;
          mem_wdata = {TAG_GONE, key_q};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[pos];
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            state <= (in_op == OP_UNUSED) ? S_RESP : S_DIV;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            state <= (probe_limit == '0) ? S_RESP : S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (op_q == OP_INSERT) begin
            state <= (rd_tag != TAG_USED || cnt == CFG_W'(1)) ? S_RESP : S_READ;
          end else begin
            state <= (rd_tag == TAG_EMPTY || key_hit || cnt == CFG_W'(1)) ? S_RESP : S_READ;
          end
        end
        S_RESP: begin
          // output register free, or freed this cycle
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid: set when the response loads, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESP && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_acc) begin
          op_q       <= in_op;
          key_q      <= in_key;
          res_status <= ST_ABSENT;
          res_slot   <= '0;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          pos        <= rem;
          cnt        <= probe_limit;
          res_status <= miss_status(op_q);
          res_slot   <= '0;
        end
      end
      S_CHECK: begin
        if ((op_q == OP_INSERT && rd_tag != TAG_USED) ||
            (op_q != OP_INSERT && key_hit)) begin
          res_status <= ST_OK;
          res_slot   <= pos;
        end else if (op_q != OP_INSERT && rd_tag == TAG_EMPTY) begin
          res_status <= ST_ABSENT;
          res_slot   <= '0;
        end else begin
          // probe miss: keep the miss status, step on
          cnt <= cnt - 1'b1;
          pos <= pos_wrap;
        end
      end
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {4'b0, slot_wide[SLOT_W-1:0], res_status};
        end
      end
      default: begin
        op_q <= op_q;
      end
    endcase
  end

  // slot number reported modulo 2**SLOT_W
  assign slot_wide = {{SLOT_W{1'b0}}, res_slot};

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ({1'b0, pos} < eff_mod))
    else $error("probe position outside modulus");

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(state == S_READ))
    else $error("check cycle without a slot read");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> (state == S_DIV))
    else $error("remainder finished outside divide state");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_RESP))
    else $error("result issued outside response state");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[11:2] == '0))
    else $error("nonzero slot on a failed transaction");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lht_pkg::*;

  localparam int DEPTH  = DEF_TABLE_DEPTH;
  localparam int KW     = DEF_KEY_WIDTH;
  localparam int S_W    = ((OP_W + KW + 7) / 8) * 8;
  // idle cycles allowed after the last result before touching the registers
  localparam int QUIET_CYCLES = 8;
  // drain time at the end: one full key remainder plus a few probes
  localparam int TAIL_CYCLES  = 2 * KW + 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
  } probe_result_t;

  // Shadow of the slot store and both registers. Every accepted transaction
  // is walked through the shadow table in acceptance order; the block works
  // on one transaction at a time, so the result stream is strictly in order.
  class probe_table_scoreboard;
    logic [TAG_W-1:0] slot_tag [DEPTH];
    logic [KW-1:0]    slot_key [DEPTH];
    logic [CFG_W-1:0] modulus_reg;
    logic [CFG_W-1:0] limit_reg;
    probe_result_t    expected_results [$];
    int               errors;

    function new();
      foreach (slot_tag[i]) begin
        slot_tag[i] = TAG_EMPTY;
        slot_key[i] = '0;
      end
      modulus_reg = CFG_RESET;
      limit_reg   = CFG_RESET;
      errors      = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_HASH_MODULUS) modulus_reg = value;
      else limit_reg = value;
    endfunction

    // Linear probe walk: home slot is key mod the effective modulus, wrap at
    // the modulus, give up after limit_reg slots.
    function probe_result_t walk_probe(logic [OP_W-1:0] op, logic [KW-1:0] key);
      probe_result_t res;
      int unsigned   mod;
      int unsigned   pos;
      int unsigned   n;
      bit            hit;
      bit            stop;
      if (modulus_reg == 0) mod = 1;
      else if (modulus_reg > DEPTH) mod = DEPTH;
      else mod = modulus_reg;
      pos  = key % mod;
      hit  = 1'b0;
      stop = 1'b0;
      res.status     = (op == OP_INSERT) ? ST_FULL : ST_ABSENT;
      res.slot_index = '0;
      if (op == OP_INSERT || op == OP_DELETE || op == OP_SEARCH) begin
        for (n = 0; n < limit_reg && !hit && !stop; n++) begin
          if (op == OP_INSERT && slot_tag[pos] != TAG_USED) begin
            // first empty or tombstoned slot; duplicates are not checked
            slot_tag[pos] = TAG_USED;
            slot_key[pos] = key;
            hit = 1'b1;
          end else if (op != OP_INSERT && slot_tag[pos] == TAG_EMPTY) begin
            stop = 1'b1;
          end else if (op != OP_INSERT && slot_tag[pos] == TAG_USED &&
                       slot_key[pos] == key) begin
            if (op == OP_DELETE) slot_tag[pos] = TAG_GONE;
            hit = 1'b1;
          end else begin
            pos = (pos + 1) % mod;
          end
        end
      end
      if (hit) begin
        res.status     = ST_OK;
        res.slot_index = pos[SLOT_W-1:0];
      end
      return res;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KW-1:0] key);
      expected_results.push_back(walk_probe(op, key));
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot);
      probe_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending: status %0d slot %0d",
                 $time, status, slot);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, status);
          errors++;
        end
        if (slot !== want.slot_index) begin
          $display("%0t: slot_index mismatch: expected %0d actual %0d",
                   $time, want.slot_index, slot);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata  = '0;   // [1:0] operation, [32:2] key, rest zero
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [15:0]    m_tdata;         // [1:0] status, [11:2] slot_index, [15:12] zero
  logic           psel     = 1'b0;
  logic           penable  = 1'b0;
  logic           pwrite   = 1'b0;
  logic [2:0]     paddr    = '0;
  logic [31:0]    pwdata   = '0;
  logic [31:0]    prdata;
  logic           pready;

  linear_probe_hash_table_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  probe_table_scoreboard sb = new();

  // percent chance per cycle that the sender holds off / the receiver stalls
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // keys inserted so far; reused so deletes and searches actually hit
  logic [KW-1:0] key_pool [$];

  // Receiver: random backpressure, redrawn every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result monitor. Sampling at the edge sees pre-edge DUT outputs.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata[1:0], m_tdata[11:2]);
    end
  end

  // Watchdog. Sized from the slowest legal run: every transaction walking its
  // full probe limit (up to 2047 probes, each a slot read and a check) plus stalls.
  initial begin
    #100_000_000;
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One transaction on the input stream. tvalid is only dropped during an
  // idle gap, so back-to-back transactions keep it high without a glitch.
  task automatic send(input logic [OP_W-1:0] op, input logic [KW-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'({key, op});
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, key);
  endtask

  // Hold the sender off until every pending result is back and the block
  // has had a few cycles to settle.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, then access; committed at the edge with pready high.
  task automatic apb_write(input logic idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] modulus, input logic [CFG_W-1:0] limit);
    wait_quiet();
    apb_write(REG_HASH_MODULUS, modulus);
    apb_write(REG_PROBE_LIMIT, limit);
  endtask

  // Random traffic: about half pooled keys so the table sees real hits, misses,
  // duplicates and tombstones; small keys stay below 4096; full-range
  // keys toggle every key bit. Unused opcode 3 shows up now and then.
  task automatic run_random(input int count);
    logic [OP_W-1:0] op;
    logic [KW-1:0]   key;
    int              r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 45) op = OP_INSERT;
      else if (r < 65) op = OP_DELETE;
      else if (r < 97) op = OP_SEARCH;
      else op = OP_UNUSED;
      r = $urandom_range(99);
      if (r < 50 && key_pool.size() > 0) key = key_pool[$urandom_range(key_pool.size() - 1)];
      else if (r < 80) key = KW'($urandom_range(4095));
      else key = KW'($urandom);
      if (op == OP_INSERT) begin
        if (key_pool.size() < 48) key_pool.push_back(key);
        else key_pool[$urandom_range(47)] = key;
      end
      send(op, key);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset registers (modulus 1024, limit 1024), no idling.
    // s_tready stays low through the clearing pass; send just waits.
    send(OP_SEARCH, 31'd5);              // empty table: stop at first empty slot
    send(OP_INSERT, 31'd0);              // lowest key -> slot 0
    send(OP_INSERT, 31'h7FFF_FFFF);      // all-ones key -> slot 1023
    send(OP_INSERT, 31'd2047);           // home 1023 taken, wraps past 0 -> 1
    send(OP_SEARCH, 31'd2047);
    send(OP_INSERT, 31'd2047);           // duplicate lands in slot 2
    send(OP_DELETE, 31'd2047);           // tombstone in slot 1
    send(OP_SEARCH, 31'd2047);           // probes past tombstone to slot 2
    send(OP_UNUSED, 31'd0);              // unused opcode: no change, not found
    send(OP_INSERT, 31'h7FFF_FFFE);
    send(OP_DELETE, 31'd12345);

    configure(11'd0, 11'd3);             // zero modulus acts as 1
    send(OP_INSERT, 31'd77);             // slot 0 busy on every probe -> full
    send(OP_SEARCH, 31'd0);

    configure(11'd0, 11'd0);             // no slot examined at all
    send(OP_INSERT, 31'd9);
    send(OP_SEARCH, 31'd0);
    send(OP_DELETE, 31'd0);

    configure(11'd2047, 11'd2047);       // modulus saturates at depth
    send(OP_SEARCH, 31'h7FFF_FFFF);
    send(OP_INSERT, 31'd1023);           // reuses the tombstone in slot 1

    configure(11'd1024, 11'd1);
    send(OP_INSERT, 31'd2046);           // single probe into a used slot

    configure(11'd2, 11'd7);             // limit above modulus: revisits slots
    send(OP_INSERT, 31'd4);
    send(OP_SEARCH, 31'd6);

    // Random phases over a spread of settings and idle patterns.
    configure(11'd1024, 11'd1024);
    src_idle_pct = 0;  sink_stall_pct = 0;
    run_random(250);

    configure(11'd37, 11'd12);
    src_idle_pct = 78; sink_stall_pct = 0;
    run_random(150);

    configure(11'd1000, 11'd64);
    src_idle_pct = 0;  sink_stall_pct = 78;
    run_random(200);

    configure(11'd8, 11'd20);
    src_idle_pct = 31; sink_stall_pct = 31;
    run_random(100);

    configure(11'd1, 11'd3);
    src_idle_pct = 0;  sink_stall_pct = 0;
    run_random(40);

    configure(11'd2047, 11'd2047);
    src_idle_pct = 31; sink_stall_pct = 31;
    run_random(200);

    // tiny modulus with the longest limit: misses walk the whole limit
    configure(11'd5, 11'd2047);
    src_idle_pct = 0;  sink_stall_pct = 0;
    run_random(15);

    configure(11'd513, 11'd0);
    src_idle_pct = 0;  sink_stall_pct = 78;
    run_random(30);

    configure(11'd0, 11'd1);
    src_idle_pct = 78; sink_stall_pct = 78;
    run_random(30);

    configure(11'd1024, 11'd1024);
    src_idle_pct = 78; sink_stall_pct = 0;
    run_random(80);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
